// ===== src/apr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_pkg: aging page replacement shared definitions
// sizes, register indexes and the command and status bundles between the
// controller and the datapath
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int FRAMES   = 16;
    localparam int AGE_BITS = 8;

    // frame index and frame count widths
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic accept;    // capture page, clear per-item state
        logic lookup;    // one step of the frame scan
        logic age;       // referenced bit, tick and aging update
        logic search;    // one step of the least-age search
        logic ev_read;   // read the page held in the chosen frame
        logic install;   // write the new page into the chosen frame
        logic load_out;  // move the result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lookup_hit;
        logic lookup_miss;
        logic is_hit;
        logic fill_free;
        logic search_done;
    } dp_status_t;

    // active frame count: zero counts as one, anything above FRAMES as FRAMES
    function automatic logic [CNT_W-1:0] clamp_frames(input logic [4:0] v);
        logic [CNT_W-1:0] r;
        if (v == 5'd0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(v) > FRAMES)
        begin
            r = CNT_W'(FRAMES);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== src/apr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_ctrl: aging page replacement controller
// sequences lookup, aging, victim search and install for one item at a time
// and owns the output valid flag
// ----------------------------------------------------------------------------
module apr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output apr_pkg::dp_cmd_t    cmd,
    input  apr_pkg::dp_status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_LOOKUP  = 7'b0000010,
        ST_AGE     = 7'b0000100,
        ST_SEARCH  = 7'b0001000,
        ST_EVREAD  = 7'b0010000,
        ST_INSTALL = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (status.lookup_hit || status.lookup_miss)
                begin
                    state_next = ST_AGE;
                end
            end
            ST_AGE:
            begin
                cmd.age = 1'b1;
                if (status.is_hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.fill_free)
                begin
                    state_next = ST_EVREAD;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_EVREAD;
                end
                else
                begin
                    cmd.search = 1'b1;
                end
            end
            ST_EVREAD:
            begin
                cmd.ev_read = 1'b1;
                state_next  = ST_INSTALL;
            end
            ST_INSTALL:
            begin
                cmd.install = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/apr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_dp: aging page replacement datapath
// page memory, frame valid, age and referenced bits, counters, the scan and
// search unit, configuration registers and the output register
// ----------------------------------------------------------------------------
module apr_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  apr_pkg::dp_cmd_t                      cmd,
    output apr_pkg::dp_status_t                   status,
    input  logic [15:0]                           page_number,
    input  logic                                  cfg_we,
    input  logic [apr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  hit,
    output logic [3:0]                            frame_index,
    output logic                                  evicted_valid,
    output logic [15:0]                           evicted_page,
    output logic [31:0]                           fault_total
);

    localparam int FR = apr_pkg::FRAMES;
    localparam int AW = apr_pkg::AGE_BITS;
    localparam int IW = apr_pkg::IDX_W;
    localparam int CW = apr_pkg::CNT_W;

    // configuration
    logic [4:0]  frames_in_use_reg;
    logic [15:0] tick_period_reg;
    logic [CW-1:0] n_eff;

    // frame state
    logic [15:0]   page_mem [FR];
    logic [FR-1:0] valid_reg;
    logic [FR-1:0] ref_reg;
    logic [AW-1:0] age_reg [FR];
    logic [CW-1:0] filled_reg;
    logic [15:0]   tick_reg;
    logic [31:0]   fault_reg;

    // per-item working registers
    logic [15:0]   page_reg;
    logic          hit_reg;
    logic [IW-1:0] slot_reg;
    logic [CW-1:0] scan_reg;
    logic [AW-1:0] best_reg;
    logic          ev_valid_reg;
    logic [15:0]   ev_page_reg;

    // memory read side
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [15:0]   rd_data_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_vld_reg;

    // output register
    logic          out_hit_reg;
    logic [IW-1:0] out_slot_reg;
    logic          out_ev_valid_reg;
    logic [15:0]   out_ev_page_reg;
    logic [31:0]   out_fault_reg;

    logic          issue;
    logic          match;
    logic          scan_end;
    logic [15:0]   tick_inc;
    logic          do_age;
    logic [FR-1:0] ref_eff;
    logic [FR-1:0] in_use;
    logic [IW-1:0] scan_idx;

    assign n_eff    = apr_pkg::clamp_frames(frames_in_use_reg);
    assign scan_end = (scan_reg >= n_eff);
    assign scan_idx = scan_reg[IW-1:0];
    assign issue    = cmd.lookup && !scan_end;
    assign match    = rd_vld_reg && valid_reg[rd_idx_reg] && (rd_data_reg == page_reg);
    assign rd_en    = issue || cmd.ev_read;
    assign rd_addr  = cmd.ev_read ? slot_reg : scan_idx;
    assign tick_inc = tick_reg + 16'd1;
    assign do_age   = !hit_reg || (tick_inc >= tick_period_reg);

    always_comb
    begin
        for (int k = 0; k < FR; k++)
        begin
            in_use[k]  = (CW'(k) < n_eff);
            ref_eff[k] = ref_reg[k] || (hit_reg && (slot_reg == IW'(k)));
        end
    end

    assign status.lookup_hit  = match;
    assign status.lookup_miss = !match && !rd_vld_reg && scan_end;
    assign status.is_hit      = hit_reg;
    assign status.fill_free   = (filled_reg < n_eff);
    assign status.search_done = scan_end;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= 5'd16;
            tick_period_reg   <= 16'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apr_pkg::CFG_FRAMES_IN_USE: frames_in_use_reg <= cfg_data[4:0];
                apr_pkg::CFG_TICK_PERIOD:   tick_period_reg   <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    // page memory, one port each way, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.install)
        begin
            page_mem[slot_reg] <= page_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= page_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= issue;
            rd_idx_reg <= scan_idx;
        end
    end

    // frame flags, ages and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            ref_reg    <= '0;
            filled_reg <= '0;
            tick_reg   <= '0;
            fault_reg  <= '0;
            for (int k = 0; k < FR; k++)
            begin
                age_reg[k] <= '0;
            end
        end
        else if (cmd.age)
        begin
            for (int k = 0; k < FR; k++)
            begin
                if (do_age && in_use[k])
                begin
                    age_reg[k] <= {ref_eff[k], age_reg[k][AW-1:1]};
                    ref_reg[k] <= 1'b0;
                end
                else
                begin
                    ref_reg[k] <= ref_eff[k];
                end
            end
            tick_reg <= do_age ? 16'd0 : tick_inc;
            if (!hit_reg)
            begin
                if (fault_reg != '1)
                begin
                    fault_reg <= fault_reg + 32'd1;
                end
                if (filled_reg < n_eff)
                begin
                    filled_reg <= filled_reg + CW'(1);
                end
            end
        end
        else if (cmd.install)
        begin
            valid_reg[slot_reg] <= 1'b1;
            ref_reg[slot_reg]   <= 1'b0;
            age_reg[slot_reg]   <= apr_pkg::AGE_TOP;
        end
    end

    // per-item control: lookup result, slot choice, least-age search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            slot_reg     <= '0;
            scan_reg     <= '0;
            ev_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            hit_reg      <= 1'b0;
            scan_reg     <= '0;
            ev_valid_reg <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            if (match)
            begin
                hit_reg  <= 1'b1;
                slot_reg <= rd_idx_reg;
            end
            else if (issue)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
        end
        else if (cmd.age)
        begin
            scan_reg <= '0;
            if (!hit_reg)
            begin
                slot_reg <= (filled_reg < n_eff) ? filled_reg[IW-1:0] : '0;
            end
        end
        else if (cmd.search)
        begin
            if (age_reg[scan_idx] < best_reg)
            begin
                slot_reg <= scan_idx;
            end
            scan_reg <= scan_reg + CW'(1);
        end
        else if (cmd.install)
        begin
            ev_valid_reg <= valid_reg[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg    <= page_number;
            ev_page_reg <= '0;
        end
        if (cmd.age)
        begin
            best_reg <= '1;
        end
        else if (cmd.search && (age_reg[scan_idx] < best_reg))
        begin
            best_reg <= age_reg[scan_idx];
        end
        if (cmd.install)
        begin
            ev_page_reg <= valid_reg[slot_reg] ? rd_data_reg : 16'd0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hit_reg      <= hit_reg;
            out_slot_reg     <= slot_reg;
            out_ev_valid_reg <= ev_valid_reg;
            out_ev_page_reg  <= ev_page_reg;
            out_fault_reg    <= fault_reg;
        end
    end

    assign hit           = out_hit_reg;
    assign frame_index   = 4'(out_slot_reg);
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign fault_total   = out_fault_reg;

endmodule

// ===== src/aging_page_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_page_replacement_unit: aging page replacement over up to 16 frames
// one page reference in, one hit/fault result out; frame lookup and least-age
// victim search run frame by frame
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall   page_number
//  output    out        out_valid / out_stall hit, frame_index, evicted_valid,
//                                             evicted_page, fault_total
//  config    in         cfg_we                cfg_index, cfg_data
//
// n = active frames: a hit ends the frame scan at the matching frame, a fault
// into an empty frame skips the victim search, and a fault with eviction
// searches all n frames; the frame scan runs through the single read port of
// the page memory and the one age comparator steps across the frames
// reset clears valid, age and referenced bits at once, so no clearing pass
// one item at a time; the next item is taken while the last result waits in
// the output register, and a stalled result holds the item in its last step
module aging_page_replacement_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // reference channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [15:0]                         page_number,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic [3:0]                          frame_index,
    output logic                                evicted_valid,
    output logic [15:0]                         evicted_page,
    output logic [31:0]                         fault_total,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [apr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // command and status bundles between the sequencer and the datapath
    apr_pkg::dp_cmd_t    cmd;
    apr_pkg::dp_status_t status;

    // controller: steps through lookup, aging, search, install, hand-off
    apr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: frame store, ages, counters and output register
    apr_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .page_number   (page_number),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

endmodule

// ===== src/apr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_checker: port-level checks for the aging page replacement unit
// watches the handshakes and the result fields over time
// ----------------------------------------------------------------------------
module apr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [3:0]  frame_index,
    input logic        evicted_valid,
    input logic [15:0] evicted_page,
    input logic [31:0] fault_total
);

    // a result held back keeps its contents
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame_index)
            && $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_total);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

    // one item at a time: taking an item closes the input
    property p_one_item;
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall;
    endproperty
    a_one_item: assert property (p_one_item) else $error("second item taken while busy");

    // a hit never evicts
    property p_hit_no_evict;
        @(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid;
    endproperty
    a_hit_no_evict: assert property (p_hit_no_evict) else $error("eviction on a hit");

    // no eviction, no evicted page
    property p_evict_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == 16'd0;
    endproperty
    a_evict_zero: assert property (p_evict_zero) else $error("stray evicted page");

    // a fault is always counted
    property p_fault_count;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> fault_total != 32'd0;
    endproperty
    a_fault_count: assert property (p_fault_count) else $error("fault not counted");

endmodule

bind aging_page_replacement_unit apr_checker u_apr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
);

// ===== bench/page_replacement_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_check_pkg: outcome predictor and scoreboard
// keeps a private copy of the frame table, ages and counters, works out the
// outcome of every accepted page reference and checks the results in order
// ----------------------------------------------------------------------------
package page_replacement_check_pkg;

    typedef struct packed {
        logic        hit;
        logic [3:0]  frame;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [31:0] faults;
    } reference_outcome_t;

    class frame_age_scoreboard;

        logic [4:0]                   frames_setting;
        logic [15:0]                  tick_setting;
        logic [15:0]                  page_of  [apr_pkg::FRAMES];
        bit                           occupied [apr_pkg::FRAMES];
        logic [apr_pkg::AGE_BITS-1:0] age_of   [apr_pkg::FRAMES];
        bit                           touched  [apr_pkg::FRAMES];
        int unsigned                  fill_level;
        logic [15:0]                  ticks;
        logic [31:0]                  fault_count;

        reference_outcome_t predicted_outcomes [$];

        int unsigned failures;
        int unsigned results_checked;
        int unsigned hits_checked;
        int unsigned evictions_checked;

        function new();
            frames_setting = 5'd16;
            tick_setting   = 16'd8;
            foreach (page_of[k])
            begin
                page_of[k]  = '0;
                occupied[k] = 1'b0;
                age_of[k]   = '0;
                touched[k]  = 1'b0;
            end
            fill_level        = 0;
            ticks             = '0;
            fault_count       = '0;
            failures          = 0;
            results_checked   = 0;
            hits_checked      = 0;
            evictions_checked = 0;
        endfunction

        function void set_register(logic [apr_pkg::CFG_IDX_W-1:0] index,
                                   logic [apr_pkg::CFG_DATA_W-1:0] data);
            case (index)
                apr_pkg::CFG_FRAMES_IN_USE: frames_setting = data[4:0];
                apr_pkg::CFG_TICK_PERIOD:   tick_setting   = data[15:0];
                default: ;
            endcase
        endfunction

        // zero frames behaves as one, oversize as the full table
        function int unsigned active_count();
            if (frames_setting == 5'd0)
                return 1;
            if (frames_setting > apr_pkg::FRAMES)
                return apr_pkg::FRAMES;
            return frames_setting;
        endfunction

        function void shift_ages(int unsigned n);
            int unsigned k;
            for (k = 0; k < n; k++)
            begin
                age_of[k]  = {touched[k], age_of[k][apr_pkg::AGE_BITS-1:1]};
                touched[k] = 1'b0;
            end
        endfunction

        function void note_reference(logic [15:0] page);
            int unsigned        n;
            int unsigned        k;
            int unsigned        slot;
            bit                 found;
            reference_outcome_t r;
            n     = active_count();
            slot  = 0;
            found = 1'b0;
            r     = '0;
            for (k = 0; k < n && !found; k++)
            begin
                if (occupied[k] && page_of[k] == page)
                begin
                    slot  = k;
                    found = 1'b1;
                end
            end
            if (found)
                touched[slot] = 1'b1;
            ticks = ticks + 16'd1;
            if (!found || ticks >= tick_setting)
            begin
                shift_ages(n);
                ticks = '0;
            end
            if (!found)
            begin
                if (fault_count != '1)
                    fault_count = fault_count + 32'd1;
                if (fill_level < n)
                begin
                    slot       = fill_level;
                    fill_level = fill_level + 1;
                end
                else
                begin
                    // lowest index wins a tie
                    slot = 0;
                    for (k = 1; k < n; k++)
                    begin
                        if (age_of[k] < age_of[slot])
                            slot = k;
                    end
                end
                if (occupied[slot])
                begin
                    r.ev_valid = 1'b1;
                    r.ev_page  = page_of[slot];
                end
                page_of[slot]  = page;
                occupied[slot] = 1'b1;
                age_of[slot]   = apr_pkg::AGE_TOP;
                touched[slot]  = 1'b0;
            end
            r.hit    = found;
            r.frame  = slot[3:0];
            r.faults = fault_count;
            predicted_outcomes.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic hit, logic [3:0] frame, logic ev_valid,
                                   logic [15:0] ev_page, logic [31:0] faults);
            reference_outcome_t want;
            if (predicted_outcomes.size() == 0)
            begin
                $display("%0t: result with no reference outstanding, frame %0h",
                         $time, frame);
                failures++;
                return;
            end
            want = predicted_outcomes.pop_front();
            compare_field("hit", want.hit, hit);
            compare_field("frame_index", want.frame, frame);
            compare_field("evicted_valid", want.ev_valid, ev_valid);
            compare_field("evicted_page", want.ev_page, ev_page);
            compare_field("fault_total", want.faults, faults);
            results_checked++;
            if (want.hit)
                hits_checked++;
            if (want.ev_valid)
                evictions_checked++;
        endfunction

        function int unsigned pending();
            return predicted_outcomes.size();
        endfunction

        function void close_out();
            if (predicted_outcomes.size() != 0)
            begin
                $display("%0t: %0d results never arrived", $time, predicted_outcomes.size());
                failures++;
            end
        endfunction

    endclass

endpackage

// ===== bench/aging_page_replacement_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_page_replacement_unit_test: self-checking bench for the aging unit
// directed references over the field extremes and the frame count and tick
// corner settings, then random phases of page streams with working-set
// locality under random input gaps and output stalls
// ----------------------------------------------------------------------------
module aging_page_replacement_unit_test;

    // spare register slots, ignored by the block
    localparam logic [apr_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [apr_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int RANDOM_ITEMS  = 1500;
    // a little over the slowest item (eviction at sixteen frames)
    localparam int SETTLE_CYCLES = 48;
    // quiet cycles tolerated: longest gap plus a full item plus a stall run, many times over
    localparam int QUIET_LIMIT   = 4000;

    localparam logic [15:0] OPENING_PAGES [19] = '{
        16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
        16'h0100, 16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h0105,
        16'h0106, 16'h0107, 16'h0108, 16'h0109, 16'h010A, 16'h010B,
        16'h0000, 16'hFFFF, 16'h1234
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] page_number = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
    logic        cfg_we = 1'b0;
    logic [apr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [apr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    page_replacement_check_pkg::frame_age_scoreboard sb = new();

    int unsigned  quiet_cycles = 0;
    int unsigned  burst_left = 0;
    int unsigned  settings_used = 0;
    int unsigned  stall_run = 0;
    stall_style_t stall_style = STALL_NONE;

    // random part bookkeeping
    int unsigned  random_sent = 0;
    int unsigned  phase_items;
    int unsigned  pick;
    logic [4:0]   frames_choice;
    logic [15:0]  frames_word;
    logic [15:0]  tick_choice;
    logic [15:0]  last_page = '0;
    logic [15:0]  next_page;
    logic [15:0]  page_pool [$];

    aging_page_replacement_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // both channels sampled on the edge with pre-edge values; a new item is
    // predicted before any result of the same edge is checked
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_reference(page_number);
        if (out_valid && !out_stall)
            sb.check_result(hit, frame_index, evicted_valid, evicted_page, fault_total);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver back-pressure: runs of free flow, light and heavy random
    // stalls, and long blocks of solid stall
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_run   = $urandom_range(10, 150);
        end
        stall_run = stall_run - 1;
        case (stall_style)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            STALL_BLOCKS: out_stall <= ((stall_run % 24) < 14);
            default:      out_stall <= 1'b0;
        endcase
    end

    // hang detector
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[aging_page_replacement_unit] ERROR");
        $finish;
    end

    // present one page reference and hold it until taken; a new burst may
    // open with a gap of random length, or with none at all
    task automatic send_reference(input logic [15:0] page);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(13, 60);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left  = burst_left - 1;
        in_valid    <= 1'b1;
        page_number <= page;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drain: stop sending, wait for every outstanding result, then let the
    // block finish any internal step before the next register write
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // the caller lowers the write enable once its writes are done
    task automatic write_register(input logic [apr_pkg::CFG_IDX_W-1:0] index,
                                  input logic [apr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.set_register(index, data);
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] frames_data, input logic [15:0] tick_data);
        write_register(apr_pkg::CFG_FRAMES_IN_USE, frames_data);
        write_register(apr_pkg::CFG_TICK_PERIOD, tick_data);
        cfg_we        <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sixteen frames, period eight; fill every frame
        // from empty, two hits, then a first eviction
        for (int i = 0; i < 19; i++)
            send_reference(OPENING_PAGES[i]);
        settle();

        // frame count of zero behaves as one frame, tick period zero ages
        // on every reference
        configure(16'd0, 16'd0);
        send_reference(16'h0000);
        send_reference(16'hBEEF);
        settle();

        // oversize frame count with junk upper bits, longest tick period,
        // and writes to the unused register slots
        write_register(CFG_SPARE_2, 16'hFFFF);
        write_register(CFG_SPARE_3, 16'h5A5A);
        configure(16'hFFFF, 16'hFFFF);
        send_reference(16'hFFFF);
        send_reference(16'hC0DE);
        settle();

        // shrink to three frames, then grow again: the upper frames kept
        // their pages meanwhile and must hit once more
        configure(16'd3, 16'd1);
        send_reference(16'hFFFF);
        send_reference(16'hD00D);
        settle();
        configure(16'd16, 16'd2);
        send_reference(16'h0105);
        send_reference(16'h0105);
        settle();

        // random phases: a working set a little larger than the frame
        // count gives a mix of hits and evictions, with repeats for
        // locality and stray pages across the whole range
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       frames_choice = 5'd1;
                1:       frames_choice = 5'd16;
                2:       frames_choice = 5'd0;
                3:       frames_choice = 5'($urandom_range(17, 31));
                default: frames_choice = 5'($urandom_range(2, 15));
            endcase
            frames_word = {11'd0, frames_choice};
            if ($urandom_range(0, 3) == 0)
                frames_word[15:5] = 11'($urandom);
            case ($urandom_range(0, 5))
                0:       tick_choice = 16'd0;
                1:       tick_choice = 16'd1;
                2:       tick_choice = 16'hFFFF;
                3:       tick_choice = 16'($urandom_range(2, 20));
                default: tick_choice = 16'($urandom);
            endcase
            configure(frames_word, tick_choice);

            page_pool.delete();
            repeat ((frames_choice == 5'd0 ? 1 : (frames_choice > 16 ? 16 : frames_choice))
                    + $urandom_range(0, 6))
                page_pool.push_back(16'($urandom));

            phase_items = $urandom_range(60, 200);
            repeat (phase_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    next_page = page_pool[$urandom_range(0, page_pool.size() - 1)];
                else if (pick < 80)
                    next_page = last_page;
                else
                    next_page = 16'($urandom);
                send_reference(next_page);
                last_page   = next_page;
                random_sent = random_sent + 1;
            end
            settle();
        end

        sb.close_out();
        $display("checked %0d references over %0d register settings", sb.results_checked,
                 settings_used + 1);
        $display("%0d hits, %0d faults, %0d evictions, with random gaps and output stalls",
                 sb.hits_checked, sb.results_checked - sb.hits_checked, sb.evictions_checked);
        if (sb.failures == 0)
            $display("[aging_page_replacement_unit] OK");
        else
            $display("[aging_page_replacement_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/apr_pkg.sv
src/apr_ctrl.sv
src/apr_dp.sv
src/aging_page_replacement_unit.sv
src/apr_checker.sv
bench/page_replacement_check_pkg.sv
bench/aging_page_replacement_unit_test.sv
